// File: rtl/quaternion_alu_unit_defines.svh
// assertion helpers for the quaternion unit
`ifndef QUATERNION_ALU_UNIT_DEFINES_SVH
`define QUATERNION_ALU_UNIT_DEFINES_SVH

// condition must hold in the same cycle as the trigger
`define QALU_ASSERT_NOW(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define QALU_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: rtl/qalu_pkg.sv
// ----------------------------------------------------------------------------
// qalu_pkg
// Shared codes and types of the quaternion unit.
// ----------------------------------------------------------------------------
package qalu_pkg;

    localparam int MODE_W = 3;

    localparam logic [MODE_W-1:0] MODE_MUL  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LDIV = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RDIV = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INV  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ROT  = 3'd4;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef struct packed {
        logic              active;
        logic [MODE_W-1:0] mode;
    } t_ctrl;

endpackage

// File: rtl/qalu_in_if.sv
// ----------------------------------------------------------------------------
// qalu_in_if
// Operation channel: mode and two quaternions.
// ----------------------------------------------------------------------------
interface qalu_in_if import qalu_pkg::*; #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic signed [CW-1:0] qa_w;
    logic signed [CW-1:0] qa_x;
    logic signed [CW-1:0] qa_y;
    logic signed [CW-1:0] qa_z;
    logic signed [CW-1:0] qb_w;
    logic signed [CW-1:0] qb_x;
    logic signed [CW-1:0] qb_y;
    logic signed [CW-1:0] qb_z;

    modport source (output valid, mode, qa_w, qa_x, qa_y, qa_z,
                    qb_w, qb_x, qb_y, qb_z, input ready);
    modport sink   (input valid, mode, qa_w, qa_x, qa_y, qa_z,
                    qb_w, qb_x, qb_y, qb_z, output ready);
endinterface

// File: rtl/qalu_out_if.sv
// ----------------------------------------------------------------------------
// qalu_out_if
// Result channel: four components and a status.
// ----------------------------------------------------------------------------
interface qalu_out_if #(parameter int CW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] res_w;
    logic signed [CW-1:0] res_x;
    logic signed [CW-1:0] res_y;
    logic signed [CW-1:0] res_z;
    logic [1:0]           status;

    modport source (output valid, res_w, res_x, res_y, res_z, status, input ready);
    modport sink   (input valid, res_w, res_x, res_y, res_z, status, output ready);
endinterface

// File: rtl/qalu_front.sv
// ----------------------------------------------------------------------------
// qalu_front
// Accepts items, decodes the mode and forms the operand quaternions.
// ----------------------------------------------------------------------------
module qalu_front import qalu_pkg::*; #(
    parameter int CW = 16
) (
    qalu_in_if.sink                 i_in,
    input  logic                    i_full,
    output logic                    o_push,
    output logic [16*(CW+1)-1:0]    o_opnd,
    output t_ctrl                   o_ctrl
);

    localparam int EW = CW + 1;

    logic signed [EW-1:0] a [4];
    logic signed [EW-1:0] b [4];
    logic signed [EW-1:0] l [4];
    logic signed [EW-1:0] r [4];
    logic signed [EW-1:0] m [4];
    logic signed [EW-1:0] c [4];

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        a[0] = EW'(i_in.qa_w);
        a[1] = EW'(i_in.qa_x);
        a[2] = EW'(i_in.qa_y);
        a[3] = EW'(i_in.qa_z);
        b[0] = EW'(i_in.qb_w);
        b[1] = EW'(i_in.qb_x);
        b[2] = EW'(i_in.qb_y);
        b[3] = EW'(i_in.qb_z);
        c[0] = a[0];
        for (int i = 1; i < 4; i++) begin
            c[i] = -a[i];
        end
        for (int i = 0; i < 4; i++) begin
            l[i] = '0;
            r[i] = '0;
            m[i] = a[i];
        end
        unique case (i_in.mode)
            MODE_MUL: begin
                l = a;
                r = b;
            end
            MODE_LDIV: begin
                l = c;
                r = b;
            end
            MODE_RDIV: begin
                l = a;
                r[0] = b[0];
                for (int i = 1; i < 4; i++) begin
                    r[i] = -b[i];
                end
                m = b;
            end
            MODE_ROT: begin
                // vector goes in as a pure quaternion
                l = a;
                for (int i = 1; i < 4; i++) begin
                    r[i] = b[i];
                end
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 4; i++) begin
            o_opnd[i*EW +: EW]      = l[i];
            o_opnd[(4+i)*EW +: EW]  = r[i];
            o_opnd[(8+i)*EW +: EW]  = m[i];
            o_opnd[(12+i)*EW +: EW] = c[i];
        end
        o_ctrl.active = (i_in.mode <= MODE_ROT);
        o_ctrl.mode   = i_in.mode;
    end

endmodule

// File: rtl/qalu_fifo.sv
// ----------------------------------------------------------------------------
// qalu_fifo
// Short queue between the decode front and the arithmetic back.
// ----------------------------------------------------------------------------
module qalu_fifo import qalu_pkg::*; #(
    parameter int W = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  logic [W-1:0]   i_data,
    input  logic           i_pop,
    output logic [W-1:0]   o_data,
    output logic [QAW:0]   o_count,
    output logic           o_full,
    output logic           o_empty
);

    logic [W-1:0]   r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_data  = r_mem[r_rp];
    assign o_count = r_cnt;
    assign o_full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/qalu_back.sv
// ----------------------------------------------------------------------------
// qalu_back
// Pipelined arithmetic: products, sums, normalize, restoring divide, clip.
// ----------------------------------------------------------------------------
module qalu_back import qalu_pkg::*; #(
    parameter int CW = 16,
    parameter int FB = 14
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_pop,
    input  logic [16*(CW+1)-1:0]    i_opnd,
    input  t_ctrl                   i_ctrl,
    qalu_out_if.source              o_out
);

    localparam int EW   = CW + 1;
    localparam int PW   = 2 * EW;
    localparam int HW   = PW + 2;
    localparam int P2W  = HW + EW;
    localparam int N4W  = P2W + 2;
    localparam int NB   = HW + FB;
    localparam int NC   = EW + 2 * FB;
    localparam int NAB  = (N4W > NB) ? N4W : NB;
    localparam int NW   = ((NAB > NC) ? NAB : NC) + 1;
    localparam int DW   = (2 * CW + 1 > FB + 1) ? 2 * CW + 1 : FB + 1;
    localparam int DDW  = DW + 1;
    localparam int QB   = CW + 1;
    localparam int UW   = NW + 1;
    localparam int CMPW = (UW > DDW + QB) ? UW : DDW + QB;

    logic en;
    logic r_out_v;

    assign en    = !r_out_v || o_out.ready;
    assign o_pop = en && i_valid;

    // operand unpack
    logic signed [EW-1:0] l [4];
    logic signed [EW-1:0] r [4];
    logic signed [EW-1:0] m [4];
    logic signed [EW-1:0] c [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            l[i] = i_opnd[i*EW +: EW];
            r[i] = i_opnd[(4+i)*EW +: EW];
            m[i] = i_opnd[(8+i)*EW +: EW];
            c[i] = i_opnd[(12+i)*EW +: EW];
        end
    end

    // stage 1: partial products and squares
    logic signed [PW-1:0] r1_p [16];
    logic signed [PW-1:0] r1_s [4];
    logic signed [EW-1:0] r1_c [4];
    t_ctrl                r1_ctrl;
    logic                 r1_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r1_p[i*4+j] <= l[i] * r[j];
                end
                r1_s[i] <= m[i] * m[i];
            end
            r1_c    <= c;
            r1_ctrl <= i_ctrl;
        end
    end

    // stage 2: first product sums and denominator
    logic signed [HW-1:0] h [4];
    logic [DW-1:0]        den;
    logic signed [HW-1:0] r2_h [4];
    logic [DW-1:0]        r2_den;
    logic signed [EW-1:0] r2_c [4];
    t_ctrl                r2_ctrl;
    logic                 r2_v;

    always_comb begin
        h[0] = HW'(r1_p[0]) - HW'(r1_p[5]) - HW'(r1_p[10]) - HW'(r1_p[15]);
        h[1] = HW'(r1_p[1]) + HW'(r1_p[4]) + HW'(r1_p[11]) - HW'(r1_p[14]);
        h[2] = HW'(r1_p[2]) - HW'(r1_p[7]) + HW'(r1_p[8]) + HW'(r1_p[13]);
        h[3] = HW'(r1_p[3]) + HW'(r1_p[6]) - HW'(r1_p[9]) + HW'(r1_p[12]);
        if (r1_ctrl.mode == MODE_MUL) begin
            den = DW'(1) << FB;
        end else begin
            den = DW'(r1_s[0]) + DW'(r1_s[1]) + DW'(r1_s[2]) + DW'(r1_s[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_h    <= h;
            r2_den  <= den;
            r2_c    <= r1_c;
            r2_ctrl <= r1_ctrl;
        end
    end

    // stage 3: products of the second rotation step
    logic signed [P2W-1:0] r3_p [16];
    logic signed [HW-1:0]  r3_h [4];
    logic signed [EW-1:0]  r3_c [4];
    logic [DW-1:0]         r3_den;
    t_ctrl                 r3_ctrl;
    logic                  r3_v;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                for (int j = 0; j < 4; j++) begin
                    r3_p[i*4+j] <= r2_h[i] * r2_c[j];
                end
            end
            r3_h    <= r2_h;
            r3_c    <= r2_c;
            r3_den  <= r2_den;
            r3_ctrl <= r2_ctrl;
        end
    end

    // stage 4: numerator by mode
    logic signed [N4W-1:0] g [4];
    logic signed [NW-1:0]  num [4];
    logic signed [NW-1:0]  r4_num [4];
    logic [DW-1:0]         r4_den;
    t_ctrl                 r4_ctrl;
    logic                  r4_v;

    always_comb begin
        g[0] = N4W'(r3_p[0]) - N4W'(r3_p[5]) - N4W'(r3_p[10]) - N4W'(r3_p[15]);
        g[1] = N4W'(r3_p[1]) + N4W'(r3_p[4]) + N4W'(r3_p[11]) - N4W'(r3_p[14]);
        g[2] = N4W'(r3_p[2]) - N4W'(r3_p[7]) + N4W'(r3_p[8]) + N4W'(r3_p[13]);
        g[3] = N4W'(r3_p[3]) + N4W'(r3_p[6]) - N4W'(r3_p[9]) + N4W'(r3_p[12]);
        for (int i = 0; i < 4; i++) begin
            unique case (r3_ctrl.mode)
                MODE_MUL:             num[i] = NW'(r3_h[i]);
                MODE_LDIV, MODE_RDIV: num[i] = NW'(r3_h[i]) <<< FB;
                MODE_INV:             num[i] = NW'(r3_c[i]) <<< (2 * FB);
                MODE_ROT:             num[i] = (i == 0) ? '0 : NW'(g[i]);
                default:              num[i] = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_num  <= num;
            r4_den  <= r3_den;
            r4_ctrl <= r3_ctrl;
        end
    end

    // divider pipeline, index 0 loaded by the normalize stage
    logic [CMPW-1:0] r_rem  [QB+1][4];
    logic [QB-1:0]   r_q    [QB+1][4];
    logic            r_neg  [QB+1][4];
    logic            r_ovf  [QB+1][4];
    logic [DDW-1:0]  r_d    [QB+1];
    logic            r_zero [QB+1];
    t_ctrl           r_dctl [QB+1];
    logic            r_dv   [QB+1];

    // stage 5: magnitude, rounding offset, overflow precheck
    logic [NW-1:0]   mag [4];
    logic [UW-1:0]   nn  [4];
    logic [DDW-1:0]  dd;

    always_comb begin
        dd = DDW'(r4_den) << 1;
        for (int i = 0; i < 4; i++) begin
            mag[i] = r4_num[i][NW-1] ? NW'(-r4_num[i]) : NW'(r4_num[i]);
            nn[i]  = (UW'(mag[i]) << 1) + UW'(r4_den);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                r_rem[0][i] <= CMPW'(nn[i]);
                r_q[0][i]   <= '0;
                r_neg[0][i] <= r4_num[i][NW-1];
                r_ovf[0][i] <= CMPW'(nn[i]) >= (CMPW'(dd) << QB);
            end
            r_d[0]    <= dd;
            r_zero[0] <= (r4_den == '0);
            r_dctl[0] <= r4_ctrl;
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_div
        localparam int K = QB - 1 - s;
        logic [CMPW-1:0] sh;
        logic            ge [4];

        always_comb begin
            sh = CMPW'(r_d[s]) << K;
            for (int i = 0; i < 4; i++) begin
                ge[i] = (r_rem[s][i] >= sh);
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                for (int i = 0; i < 4; i++) begin
                    r_rem[s+1][i] <= ge[i] ? r_rem[s][i] - sh : r_rem[s][i];
                    r_q[s+1][i]   <= r_q[s][i] | (QB'(ge[i]) << K);
                    r_neg[s+1][i] <= r_neg[s][i];
                    r_ovf[s+1][i] <= r_ovf[s][i];
                end
                r_d[s+1]    <= r_d[s];
                r_zero[s+1] <= r_zero[s];
                r_dctl[s+1] <= r_dctl[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[s+1] <= 1'b0;
            end else if (en) begin
                r_dv[s+1] <= r_dv[s];
            end
        end
    end

    // valid chain of the fixed stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            r4_v    <= 1'b0;
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            r4_v    <= r3_v;
            r_dv[0] <= r4_v;
        end
    end

    // clip and status
    localparam logic [QB-1:0] HALF = QB'(1) << (CW - 1);

    logic signed [CW-1:0] res [4];
    logic                 sat [4];
    logic [1:0]           st;
    logic [QB-1:0]        qv;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qv = r_q[QB][i];
            if (r_neg[QB][i]) begin
                sat[i] = r_ovf[QB][i] || (qv > HALF);
                res[i] = sat[i] ? {1'b1, {(CW-1){1'b0}}} : -qv[CW-1:0];
            end else begin
                sat[i] = r_ovf[QB][i] || (qv > HALF - 1'b1);
                res[i] = sat[i] ? {1'b0, {(CW-1){1'b1}}} : qv[CW-1:0];
            end
        end
        st = (sat[0] || sat[1] || sat[2] || sat[3]) ? ST_SAT : ST_OK;
        if (r_dctl[QB].mode == MODE_ROT) begin
            res[0] = '0;
        end
        if (!r_dctl[QB].active) begin
            st = ST_OK;
            for (int i = 0; i < 4; i++) begin
                res[i] = '0;
            end
        end else if (r_zero[QB]) begin
            st = ST_DIVZERO;
            for (int i = 0; i < 4; i++) begin
                res[i] = '0;
            end
        end
    end

    logic signed [CW-1:0] r_res [4];
    logic [1:0]           r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_dv[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= res;
            r_st  <= st;
        end
    end

    assign o_out.valid  = r_out_v;
    assign o_out.res_w  = r_res[0];
    assign o_out.res_x  = r_res[1];
    assign o_out.res_y  = r_res[2];
    assign o_out.res_z  = r_res[3];
    assign o_out.status = r_st;

endmodule

// File: rtl/quaternion_alu_unit.sv
// ----------------------------------------------------------------------------
// quaternion_alu_unit
// Fixed-point quaternion product, quotients, inverse and vector rotation.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in      in   valid/ready    mode, qa_w..qa_z, qb_w..qb_z
//  o_out     out  valid/ready    res_w..res_z, status
//
//  one item per cycle sustained while the output is not stalled; the
//  restoring divider yields one quotient bit per stage
//  synchronous active-low reset empties the queue and the pipeline
//  a stalled output holds the pipeline; the four-entry queue keeps taking
//  items until it is full
// ----------------------------------------------------------------------------
`include "quaternion_alu_unit_defines.svh"

module quaternion_alu_unit import qalu_pkg::*; #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qalu_in_if.sink     i_in,
    qalu_out_if.source  o_out
);

    localparam int OPW = 16 * (COMPONENT_WIDTH + 1);
    localparam int CTW = $bits(t_ctrl);
    localparam int QW  = OPW + CTW;

    logic [OPW-1:0] w_opnd;
    t_ctrl          w_ctrl;
    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_empty;
    logic [QAW:0]   w_cnt;
    logic [QW-1:0]  w_head;

    qalu_front #(.CW(COMPONENT_WIDTH)) u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_opnd (w_opnd),
        .o_ctrl (w_ctrl)
    );

    qalu_fifo #(.W(QW)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_ctrl, w_opnd}),
        .i_pop   (w_pop),
        .o_data  (w_head),
        .o_count (w_cnt),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    qalu_back #(.CW(COMPONENT_WIDTH), .FB(FRACTION_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_empty),
        .o_pop   (w_pop),
        .i_opnd  (w_head[OPW-1:0]),
        .i_ctrl  (t_ctrl'(w_head[QW-1 -: CTW])),
        .o_out   (o_out)
    );

    `QALU_ASSERT_NOW(a_stall_holds_queue, o_out.valid && !o_out.ready, !w_pop, "queue popped while output stalled")
    `QALU_ASSERT_NEXT(a_push_counts, w_push && !w_pop, w_cnt == $past(w_cnt) + 1'b1, "queue count missed a push")
    `QALU_ASSERT_NOW(a_divzero_clears, o_out.valid && o_out.status == ST_DIVZERO, o_out.res_w == '0 && o_out.res_x == '0 && o_out.res_y == '0 && o_out.res_z == '0, "zero magnitude with nonzero result")

endmodule
